// ===== rtl/core/atsa_pkg.sv =====
`default_nettype none

package atsa_pkg;

    localparam int NUM_TILES   = 22;
    localparam int OWNER_WIDTH = 16;
    localparam int IDX_W       = $clog2(NUM_TILES);
    localparam int CNT_W       = 5;
    localparam int CLAIM_W     = 8;
    localparam int CAP_W       = 9;
    localparam int OPC_W       = 3;
    localparam int CLASS_W     = 2;
    localparam int OWNER_IN_W  = 16;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 16;

    localparam int HALF_END    = 2;
    localparam int QUARTER_END = 6;

    localparam logic [CLAIM_W-1:0] CLAIM_MAX = '1;
    localparam logic [CAP_W-1:0]   CAP_RESET = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_BEGIN    = 3'd0,
        OP_END      = 3'd1,
        OP_ACQUIRE  = 3'd2,
        OP_RESERVE  = 3'd3,
        OP_CAPACITY = 3'd4,
        OP_OWNER    = 3'd5
    } opcode_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_HALF    = 2'd0,
        CLASS_QUARTER = 2'd1,
        CLASS_EIGHTH  = 2'd2
    } tile_class_t;

    typedef enum logic [2:0] {
        RSP_NONE,
        RSP_OK,
        RSP_DENY,
        RSP_QUERY,
        RSP_GRANT
    } resp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_OWN,
        ST_SCAN_FREE,
        ST_SCAN_QUERY,
        ST_EMIT,
        ST_RESP_OK,
        ST_RESP_DENY,
        ST_RESP_QUERY
    } state_t;

    typedef struct packed {
        logic  load;
        logic  clear;
        logic  begin_frame;
        logic  end_frame;
        logic  scan_own;
        logic  scan_free;
        logic  scan_query;
        logic  grant;
        logic  emit;
        resp_t resp;
    } cmd_t;

    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             acq_deny;
        logic             scan_last;
        logic             found_full;
        logic             count_zero;
        logic             out_free;
        logic             emit_last;
    } stat_t;

    function automatic logic [CLASS_W-1:0] class_of(input logic [IDX_W-1:0] idx);
        logic [CLASS_W-1:0] c;
        if (idx < IDX_W'(HALF_END)) begin
            c = CLASS_HALF;
        end else if (idx < IDX_W'(QUARTER_END)) begin
            c = CLASS_QUARTER;
        end else begin
            c = CLASS_EIGHTH;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/atlas_tile_slot_allocator_top.sv =====
`default_nettype none

// Allocator for a fixed shadow atlas of 22 tiles (two half, four quarter and sixteen eighth
// size tiles). One command word enters on the s_ side; its results leave on the m_ side
// from an output register, so a new command is taken while the last result word still
// waits. Commands run one at a time, and the tile table is walked by one scan index, one
// tile per cycle. Begin frame, end frame, unknown opcodes and acquires denied for a zero
// count or the claim cap go from dispatch straight to their single result word. Capacity
// and owner queries walk the table once before their result word. A reserve walks the
// table once and an acquire twice; each then gives one result word per granted tile,
// one result word per cycle while the output side keeps up. A reserve of zero tiles, or a
// reserve or an acquire denied for short supply, gives a single result word. A result word
// left waiting in the output register stalls the next one. The user must write the claim
// cap through the cfg port only while no command is in flight; the block does not check.

module atlas_tile_slot_allocator_top
    import atsa_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // opcode[2:0], tile_class[4:3], owner_id[20:5], tile_count[25:21], zero[31:26]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // ok[0], slot_valid[1], slot_index[6:2], answer[11:7], zero[15:12]
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CAP_W-1:0]    cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    atsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    atsa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/core/atsa_ctrl.sv =====
`default_nettype none

module atsa_ctrl
    import atsa_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.resp   = RSP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.clear = 1'b1;
                unique case (stat.op) inside
                    OP_BEGIN: begin
                        cmd.begin_frame = 1'b1;
                        state_next      = ST_RESP_OK;
                    end
                    OP_END: begin
                        cmd.end_frame = 1'b1;
                        state_next    = ST_RESP_OK;
                    end
                    OP_ACQUIRE: begin
                        state_next = stat.acq_deny ? ST_RESP_DENY : ST_SCAN_OWN;
                    end
                    OP_RESERVE: begin
                        state_next = ST_SCAN_FREE;
                    end
                    OP_CAPACITY, OP_OWNER: begin
                        state_next = ST_SCAN_QUERY;
                    end
                    default: begin
                        state_next = ST_RESP_DENY;
                    end
                endcase
            end
            ST_SCAN_OWN: begin
                cmd.scan_own = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_SCAN_FREE;
                end
            end
            ST_SCAN_FREE: begin
                cmd.scan_free = 1'b1;
                if (stat.scan_last) begin
                    if (!stat.found_full) begin
                        state_next = ST_RESP_DENY;
                    end else if (stat.count_zero) begin
                        state_next = ST_RESP_OK;
                    end else begin
                        cmd.grant  = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN_QUERY: begin
                cmd.scan_query = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_RESP_QUERY;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.resp = RSP_GRANT;
                    if (stat.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RESP_OK: begin
                if (stat.out_free) begin
                    cmd.resp   = RSP_OK;
                    state_next = ST_IDLE;
                end
            end
            ST_RESP_DENY: begin
                if (stat.out_free) begin
                    cmd.resp   = RSP_DENY;
                    state_next = ST_IDLE;
                end
            end
            ST_RESP_QUERY: begin
                if (stat.out_free) begin
                    cmd.resp   = RSP_QUERY;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/atsa_dp.sv =====
`default_nettype none

module atsa_dp
    import atsa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic                  cfg_valid,
    input  wire logic [CAP_W-1:0]      cfg_data,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,
    output logic                       m_tlast
);

    logic [OPC_W-1:0]       op_reg;
    logic [CLASS_W-1:0]     cls_reg;
    logic [OWNER_WIDTH-1:0] req_owner_reg;
    logic [CNT_W-1:0]       count_reg;

    logic [OWNER_WIDTH-1:0] tile_owner_reg [NUM_TILES];
    logic [NUM_TILES-1:0]   tile_pinned_reg;
    logic [NUM_TILES-1:0]   tile_claimed_reg;
    logic [CLAIM_W-1:0]     frame_claims_reg;
    logic [CAP_W-1:0]       claim_cap_reg;

    logic [IDX_W-1:0]       scan_idx_reg;
    logic [NUM_TILES-1:0]   taken_reg;
    logic [IDX_W-1:0]       pick_reg [NUM_TILES];
    logic [CNT_W-1:0]       found_reg;
    logic [CNT_W-1:0]       emit_idx_reg;
    logic [CNT_W-1:0]       cap_cnt_reg;
    logic                   has_reg;

    logic                   out_valid_reg;
    logic                   out_ok_reg;
    logic                   out_slot_valid_reg;
    logic [IDX_W-1:0]       out_slot_index_reg;
    logic [CNT_W-1:0]       out_answer_reg;
    logic                   out_last_reg;

    logic [OWNER_WIDTH-1:0] scan_owner;
    logic                   class_hit;
    logic                   match_own;
    logic                   match_free;
    logic                   push;
    logic [IDX_W-1:0]       tile_sel;
    logic                   emit_last;
    logic                   out_free;
    logic [CLAIM_W+1:0]     claim_sum;
    logic [CLAIM_W:0]       claim_add;

    assign scan_owner = tile_owner_reg[scan_idx_reg];
    assign class_hit  = (class_of(scan_idx_reg) == cls_reg);
    assign match_own  = class_hit && (scan_owner == req_owner_reg);
    assign match_free = class_hit && (scan_owner == '0) && !taken_reg[scan_idx_reg];
    assign push       = (found_reg < count_reg)
                        && ((cmd.scan_own && match_own) || (cmd.scan_free && match_free));
    assign tile_sel   = pick_reg[emit_idx_reg[IDX_W-1:0]];
    assign emit_last  = ((emit_idx_reg + CNT_W'(1)) == found_reg);
    assign out_free   = !out_valid_reg || m_tready;
    assign claim_sum  = {2'b00, frame_claims_reg} + (CLAIM_W+2)'(count_reg);
    assign claim_add  = {1'b0, frame_claims_reg} + (CLAIM_W+1)'(count_reg);

    always_comb begin
        stat            = '0;
        stat.op         = op_reg;
        stat.acq_deny   = (count_reg == '0)
                          || (!claim_cap_reg[CAP_W-1]
                              && (claim_sum > (CLAIM_W+2)'(claim_cap_reg)));
        stat.scan_last  = (scan_idx_reg == IDX_W'(NUM_TILES - 1));
        stat.found_full = ((found_reg + CNT_W'(push)) == count_reg);
        stat.count_zero = (count_reg == '0);
        stat.out_free   = out_free;
        stat.emit_last  = emit_last;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= s_tdata[2:0];
            cls_reg       <= s_tdata[4:3];
            req_owner_reg <= OWNER_WIDTH'(s_tdata[20:5]);
            count_reg     <= s_tdata[25:21];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            claim_cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            claim_cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TILES; i++) begin
                tile_owner_reg[i] <= '0;
            end
            tile_pinned_reg  <= '0;
            tile_claimed_reg <= '0;
            frame_claims_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_TILES; i++) begin
                if (cmd.end_frame && !tile_pinned_reg[i] && !tile_claimed_reg[i]
                    && (tile_owner_reg[i] != '0)) begin
                    tile_owner_reg[i] <= '0;
                end
                if (cmd.emit && (tile_sel == IDX_W'(i))) begin
                    tile_owner_reg[i] <= req_owner_reg;
                    if (op_reg == OP_ACQUIRE) begin
                        tile_claimed_reg[i] <= 1'b1;
                    end else begin
                        tile_pinned_reg[i] <= 1'b1;
                    end
                end
            end
            if (cmd.begin_frame) begin
                tile_claimed_reg <= '0;
                frame_claims_reg <= '0;
            end
            if (cmd.grant && (op_reg == OP_ACQUIRE)) begin
                frame_claims_reg <= claim_add[CLAIM_W] ? CLAIM_MAX : claim_add[CLAIM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            scan_idx_reg <= '0;
            taken_reg    <= '0;
            found_reg    <= '0;
            emit_idx_reg <= '0;
            cap_cnt_reg  <= '0;
            has_reg      <= 1'b0;
        end else begin
            if (cmd.scan_own || cmd.scan_free || cmd.scan_query) begin
                scan_idx_reg <= stat.scan_last ? '0 : scan_idx_reg + IDX_W'(1);
            end
            if (push) begin
                pick_reg[found_reg[IDX_W-1:0]] <= scan_idx_reg;
                taken_reg[scan_idx_reg]        <= 1'b1;
                found_reg                      <= found_reg + CNT_W'(1);
            end
            if (cmd.scan_query) begin
                if (class_hit && !tile_pinned_reg[scan_idx_reg]) begin
                    cap_cnt_reg <= cap_cnt_reg + CNT_W'(1);
                end
                if (scan_owner == req_owner_reg) begin
                    has_reg <= 1'b1;
                end
            end
            if (cmd.emit) begin
                emit_idx_reg <= emit_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.resp != RSP_NONE) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.resp != RSP_NONE) begin
            out_ok_reg         <= 1'b0;
            out_slot_valid_reg <= 1'b0;
            out_slot_index_reg <= '0;
            out_answer_reg     <= '0;
            out_last_reg       <= 1'b1;
            case (cmd.resp)
                RSP_OK: begin
                    out_ok_reg <= 1'b1;
                end
                RSP_QUERY: begin
                    if (op_reg == OP_CAPACITY) begin
                        out_ok_reg     <= 1'b1;
                        out_answer_reg <= cap_cnt_reg;
                    end else begin
                        out_ok_reg <= has_reg;
                    end
                end
                RSP_GRANT: begin
                    out_ok_reg         <= 1'b1;
                    out_slot_valid_reg <= 1'b1;
                    out_slot_index_reg <= tile_sel;
                    out_last_reg       <= emit_last;
                end
                default: begin
                    out_ok_reg <= 1'b0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_answer_reg, out_slot_index_reg,
                       out_slot_valid_reg, out_ok_reg};

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (emit_idx_reg < found_reg))
        else $error("Grant word issued beyond the gathered tile list.");

    a_emit_op: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> ((op_reg == OP_ACQUIRE) || (op_reg == OP_RESERVE)))
        else $error("Grant word issued for an operation that grants no tiles.");

    a_found_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_own || cmd.scan_free) |-> (found_reg <= count_reg))
        else $error("Gathered more tiles than requested.");

    a_grant_commits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (tile_owner_reg[$past(tile_sel)] == $past(req_owner_reg)))
        else $error("Granted tile did not take the requester as owner.");

endmodule

`default_nettype wire
